/* rtl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

   localparam int CNT_W_DEFAULT = 20;
   localparam int TLEN_W        = 10;
   localparam int TMO_W         = 20;
   localparam int DIST_W        = 15;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd1;

   localparam logic [TLEN_W-1:0] TLEN_RESET = 10'd10;
   localparam logic [TMO_W-1:0]  TMO_RESET  = 20'd900000;

   // Divide by 58 as multiply by reciprocal; exact for inputs below 2^21
   localparam int  CM_DIVISOR = 58;
   localparam int  DIV_IN_W   = 21;
   localparam int  RECIP_SH   = 27;
   localparam int  RECIP_W    = 23;
   localparam logic [RECIP_W-1:0] RECIP = 23'd2314099;
   // Any count at or above this saturates the distance
   localparam logic [32:0] SAT_LIMIT = 33'(CM_DIVISOR * 32768);
   localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_TRIG      = 4'b0010,
      PH_WAIT_RISE = 4'b0100,
      PH_HIGH      = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TLEN_W-1:0] trig_len;
      logic [TMO_W-1:0]  timeout;
   } cfg_type;

   typedef struct packed {
      logic              trig_level;
      logic              busy_res;
      logic              done_res;
      logic              timed_out;
      logic [DIST_W-1:0] range_cm;
   } result_type;

endpackage

/* rtl/uer_div58.sv */
// Saturating divide of the echo width by 58 to get centimeters.
module uer_div58
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
   input  logic [COUNT_WIDTH-1:0] width_ticks,
   output logic [DIST_W-1:0]      range_cm
);

   logic [32:0]                  width_ext;
   logic                         sat;
   logic [DIV_IN_W-1:0]          width_low;
   logic [DIV_IN_W+RECIP_W-1:0]  prod;

   assign width_ext = {{(33-COUNT_WIDTH){1'b0}}, width_ticks};
   assign sat       = (width_ext >= SAT_LIMIT);
   assign width_low = width_ext[DIV_IN_W-1:0];
   assign prod      = {{RECIP_W{1'b0}}, width_low} * {{DIV_IN_W{1'b0}}, RECIP};

   assign range_cm = sat ? DIST_MAX : prod[RECIP_SH +: DIST_W];

endmodule

/* rtl/uer_core.sv */
// Measurement sequencer: phase, tick counter and last distance.
module uer_core
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       start_req,
   input  logic       echo,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type               phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;

   logic [COUNT_WIDTH-1:0]  cnt_mask;
   logic [COUNT_WIDTH-1:0]  cnt_inc;
   logic [COUNT_WIDTH-1:0]  bump_base;
   logic [COUNT_WIDTH-1:0]  bumped;
   logic [32:0]             inc_ext;
   logic [32:0]             bumped_ext;
   logic [32:0]             tlen_ext;
   logic [32:0]             tmo_ext;
   logic                    tout_hit;
   logic [DIST_W-1:0]       div_q;
   logic                    trig, busy, done, tout;

   uer_div58 #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
      .width_ticks (cnt_ff),
      .range_cm    (div_q)
   );

   assign cnt_mask   = '1;
   assign cnt_inc    = cnt_ff + COUNT_WIDTH'(1);
   // rising edge restarts the count, that tick being the first high sample
   assign bump_base  = (phase_ff == PH_WAIT_RISE && echo) ? '0 : cnt_ff;
   assign bumped     = (bump_base != cnt_mask) ? bump_base + COUNT_WIDTH'(1) : bump_base;
   assign inc_ext    = {{(33-COUNT_WIDTH){1'b0}}, cnt_inc};
   assign bumped_ext = {{(33-COUNT_WIDTH){1'b0}}, bumped};
   assign tlen_ext   = {{(33-TLEN_W){1'b0}}, cfg.trig_len};
   assign tmo_ext    = {{(33-TMO_W){1'b0}}, cfg.timeout};
   assign tout_hit   = (bumped_ext >= tmo_ext) || (bumped == cnt_mask);

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      dist_in  = dist_ff;
      trig     = 1'b0;
      busy     = 1'b0;
      done     = 1'b0;
      tout     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               trig = 1'b1;
               busy = 1'b1;
               if (cfg.trig_len <= TLEN_W'(1)) begin
                  phase_in = PH_WAIT_RISE;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_TRIG;
                  cnt_in   = COUNT_WIDTH'(1);
               end
            end
         end
         PH_TRIG: begin
            trig = 1'b1;
            busy = 1'b1;
            if (inc_ext >= tlen_ext) begin
               phase_in = PH_WAIT_RISE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT_RISE: begin
            busy   = 1'b1;
            cnt_in = bumped;
            if (echo) begin
               phase_in = PH_HIGH;
            end
            tout = tout_hit;
         end
         PH_HIGH: begin
            busy = 1'b1;
            if (echo) begin
               cnt_in = bumped;
               tout   = tout_hit;
            end else begin
               dist_in  = div_q;
               done     = 1'b1;
               phase_in = PH_IDLE;
               cnt_in   = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cnt_in   = '0;
         end
      endcase
      if (tout) begin
         done     = 1'b1;
         dist_in  = '0;
         phase_in = PH_IDLE;
         cnt_in   = '0;
      end
   end

   assign result.trig_level = trig;
   assign result.busy_res   = busy;
   assign result.done_res   = done;
   assign result.timed_out  = tout;
   assign result.range_cm   = dist_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         dist_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         dist_ff  <= dist_in;
      end
   end

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger: channels, registers and checks.
//
// Each request on req_ is one microsecond tick carrying req_start_req and the
// sampled req_echo level. Every request yields exactly one response on rsp_:
// trigger level, busy, done, timeout flag and the last distance in cm.
// A start on an idle tick raises the trigger for trigger_length ticks, at
// least one, then the block waits for echo to rise and counts the high
// ticks; an echo fall reports width / 58, a wait that reaches timeout_ticks
// reports 0 with rsp_timed_out set.
// A request accepted on req_ lands in the input register; when the
// sequencer advances it passes through the sequencer into the response
// register, where the response is presented as valid on rsp_.
// Throughput: one request per cycle unless req_stall is raised; the
// per-tick update is one counter increment and compare plus the
// divide-by-58 multiply.
// Reset clears the phase, counter, last distance and the valid flags of both
// pipeline stages, and loads trigger_length = 10, timeout_ticks = 900000.
// rsp_stall holds the response register; req_stall rises only when the input
// register is also full. CSR writes (index 0 trigger_length, 1 timeout_ticks)
// are always ready and belong in idle periods.
module ultrasonic_echo_ranger
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_req,
   input  logic                  req_echo,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_trig_level,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_timed_out,
   output logic [DIST_W-1:0]     rsp_range_cm,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       start_ff;
   logic       echo_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type core_result;
   logic       advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trig_len <= TLEN_RESET;
         cfg_ff.timeout  <= TMO_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIG_LEN: cfg_ff.trig_len <= csr_data[TLEN_W-1:0];
            CSR_TIMEOUT:  cfg_ff.timeout  <= csr_data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         start_ff <= req_start_req;
         echo_ff  <= req_echo;
      end
   end

   uer_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .start_req (start_ff),
      .echo      (echo_ff),
      .cfg       (cfg_ff),
      .result    (core_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_trig_level = out_ff.trig_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_timed_out  = out_ff.timed_out;
   assign rsp_range_cm   = out_ff.range_cm;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done response without busy");

   a_tout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_done_res && (rsp_range_cm == '0))
      else $error("timeout response without done or with nonzero distance");

   a_trig_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trig_level |-> !rsp_done_res)
      else $error("measurement finished while trigger high");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && req_stall |=> in_valid_ff && $stable(start_ff) && $stable(echo_ff))
      else $error("input register lost a request while stalled");

endmodule
